@@ src/lbs_pkg.sv @@
// Shared constants and types for the letterbox nearest-neighbor scaler address block.
// Used by lbs_geom and by letterbox_nearest_scaler_address. It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lbs_pkg;

	localparam int LEN_BITS      = 24;
	localparam int CFG_DATA_BITS = 24;
	localparam int CFG_IDX_BITS  = 3;
	localparam int TARGET_RESET  = 240;

	localparam logic [CFG_IDX_BITS-1:0] REG_SRC_WIDTH    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SRC_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SRC_STRIDE   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_LENGTH = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_SIZE  = 3'd4;

	typedef enum logic [4:0] {
		GEO_IDLE = 5'b00001,
		GEO_PREP = 5'b00010,
		GEO_CHK  = 5'b00100,
		GEO_DIVW = 5'b01000,
		GEO_DIVH = 5'b10000
	} geo_state_t;

endpackage

`default_nettype wire

@@ src/lbs_geom.sv @@
// Geometry unit: derives validity, effective stride, scaled size and centering offsets
// from the configuration with one shared iterative divider. Depends on lbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbs_geom #(
	parameter int COORD_BITS  = 12,
	parameter int CANVAS_BITS = 10
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         restart,
	input  wire logic [COORD_BITS-1:0]        width,
	input  wire logic [COORD_BITS-1:0]        height,
	input  wire logic [COORD_BITS-1:0]        stride_raw,
	input  wire logic [lbs_pkg::LEN_BITS-1:0] frame_len,
	input  wire logic [CANVAS_BITS-1:0]       target,
	output logic                              busy,
	output logic                              ok,
	output logic [COORD_BITS-1:0]             stride,
	output logic [CANVAS_BITS-1:0]            sw,
	output logic [CANVAS_BITS-1:0]            sh,
	output logic [CANVAS_BITS-1:0]            xo,
	output logic [CANVAS_BITS-1:0]            yo
);

	localparam int NW = COORD_BITS + CANVAS_BITS;
	localparam int CW = $clog2(NW + 1);
	localparam int PW = 2 * COORD_BITS;
	localparam int CMPW = (PW > lbs_pkg::LEN_BITS) ? PW : lbs_pkg::LEN_BITS;

	lbs_pkg::geo_state_t state_q;
	logic [COORD_BITS-1:0]  stride_q;
	logic [NW-1:0]          wt_q, ht_q;
	logic [NW-1:0]          num_q;
	logic [COORD_BITS-1:0]  rem_q;
	logic [COORD_BITS-1:0]  den_q;
	logic [CW-1:0]          cnt_q;
	logic                   ok_q;
	logic [CANVAS_BITS-1:0] sw_q, sh_q, xo_q, yo_q;

	logic [COORD_BITS:0]    trial;
	logic                   ge;
	logic [NW-1:0]          num_next;
	logic [PW-1:0]          need;
	logic                   last_step;
	logic [CANVAS_BITS-1:0] clamp_q;
	logic [CANVAS_BITS-1:0] half_gap;

	assign trial     = {rem_q, num_q[NW-1]};
	assign ge        = trial >= {1'b0, den_q};
	assign num_next  = {num_q[NW-2:0], ge};
	assign need      = stride_q * height;
	assign last_step = cnt_q == CW'(NW - 1);

	// Quotient clamped to the canvas side and kept at one pixel or more.
	always_comb begin
		if (num_next >= NW'(target)) begin
			clamp_q = target;
		end else if (num_next == '0) begin
			clamp_q = CANVAS_BITS'(1);
		end else begin
			clamp_q = num_next[CANVAS_BITS-1:0];
		end
		half_gap = (target - clamp_q) >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbs_pkg::GEO_PREP;
			cnt_q   <= '0;
		end else if (restart) begin
			state_q <= lbs_pkg::GEO_PREP;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				lbs_pkg::GEO_IDLE: begin
					state_q <= lbs_pkg::GEO_IDLE;
				end
				lbs_pkg::GEO_PREP: begin
					state_q <= lbs_pkg::GEO_CHK;
				end
				lbs_pkg::GEO_CHK: begin
					state_q <= lbs_pkg::GEO_DIVW;
					cnt_q   <= '0;
				end
				lbs_pkg::GEO_DIVW: begin
					cnt_q <= last_step ? '0 : cnt_q + CW'(1);
					if (last_step) begin
						state_q <= lbs_pkg::GEO_DIVH;
					end
				end
				lbs_pkg::GEO_DIVH: begin
					cnt_q <= last_step ? '0 : cnt_q + CW'(1);
					if (last_step) begin
						state_q <= lbs_pkg::GEO_IDLE;
					end
				end
				default: begin
					state_q <= lbs_pkg::GEO_PREP;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			lbs_pkg::GEO_PREP: begin
				stride_q <= (stride_raw == '0) ? width : stride_raw;
				wt_q     <= NW'(width * target);
				ht_q     <= NW'(height * target);
			end
			lbs_pkg::GEO_CHK: begin
				ok_q  <= (width != '0) && (height != '0) && (stride_q >= width) &&
				         (CMPW'(frame_len) >= CMPW'(need));
				num_q <= wt_q;
				den_q <= height;
				rem_q <= '0;
			end
			lbs_pkg::GEO_DIVW: begin
				if (last_step) begin
					sw_q  <= clamp_q;
					xo_q  <= half_gap;
					num_q <= ht_q;
					den_q <= width;
					rem_q <= '0;
				end else begin
					rem_q <= ge ? COORD_BITS'(trial - {1'b0, den_q}) : trial[COORD_BITS-1:0];
					num_q <= num_next;
				end
			end
			lbs_pkg::GEO_DIVH: begin
				rem_q <= ge ? COORD_BITS'(trial - {1'b0, den_q}) : trial[COORD_BITS-1:0];
				num_q <= num_next;
				if (last_step) begin
					sh_q <= clamp_q;
					yo_q <= half_gap;
				end
			end
			default: begin
				ok_q <= ok_q;
			end
		endcase
	end

	assign busy   = state_q != lbs_pkg::GEO_IDLE;
	assign ok     = ok_q;
	assign stride = stride_q;
	assign sw     = sw_q;
	assign sh     = sh_q;
	assign xo     = xo_q;
	assign yo     = yo_q;

endmodule

`default_nettype wire

@@ src/letterbox_nearest_scaler_address.sv @@
// Top level of the letterbox nearest-neighbor scaler address block: configuration registers
// and the per-item pipeline. Depends on lbs_pkg and lbs_geom.
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------
//   cfg      | cfg_we              | cfg_index, cfg_data
//   in       | in_valid, in_ready  | canvas_x, canvas_y
//   out      | out_valid, out_ready| frame_ok, in_image, src_index
//
// One item per cycle is accepted while the geometry unit is idle and no output stall backs up
// to stage 1. The pipelined divider spends one stage on each source coordinate bit.
// After reset and after every configuration write, in_ready stays low while the geometry
// unit recomputes the scaled size. A stall on the output fills bubbles first and then holds
// every stage in place.
`timescale 1ns / 1ps
`default_nettype none

module letterbox_nearest_scaler_address #(
	parameter int COORD_BITS  = 12,
	parameter int CANVAS_BITS = 10
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [lbs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [lbs_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [CANVAS_BITS-1:0]            canvas_x,
	input  wire logic [CANVAS_BITS-1:0]            canvas_y,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   frame_ok,
	output logic                                   in_image,
	output logic [lbs_pkg::LEN_BITS-1:0]           src_index
);

	localparam int CO   = COORD_BITS;
	localparam int CB   = CANVAS_BITS;
	localparam int NW   = CO + CB;
	localparam int LB   = lbs_pkg::LEN_BITS;
	localparam int PW   = 2 * CO;
	localparam int SUMW = (PW > LB) ? PW : LB;

	// Configuration registers.
	logic [CO-1:0] width_q, height_q, stride_raw_q;
	logic [LB-1:0] frame_len_q;
	logic [CB-1:0] target_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= '0;
			height_q     <= '0;
			stride_raw_q <= '0;
			frame_len_q  <= '0;
			target_q     <= CB'(lbs_pkg::TARGET_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				lbs_pkg::REG_SRC_WIDTH:    width_q      <= cfg_data[CO-1:0];
				lbs_pkg::REG_SRC_HEIGHT:   height_q     <= cfg_data[CO-1:0];
				lbs_pkg::REG_SRC_STRIDE:   stride_raw_q <= cfg_data[CO-1:0];
				lbs_pkg::REG_FRAME_LENGTH: frame_len_q  <= cfg_data[LB-1:0];
				lbs_pkg::REG_TARGET_SIZE:  target_q     <= cfg_data[CB-1:0];
				default: begin
					width_q <= width_q;
				end
			endcase
		end
	end

	logic          geo_busy, geo_ok;
	logic [CO-1:0] geo_stride;
	logic [CB-1:0] geo_sw, geo_sh, geo_xo, geo_yo;

	lbs_geom #(
		.COORD_BITS (CO),
		.CANVAS_BITS(CB)
	) u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (cfg_we),
		.width     (width_q),
		.height    (height_q),
		.stride_raw(stride_raw_q),
		.frame_len (frame_len_q),
		.target    (target_q),
		.busy      (geo_busy),
		.ok        (geo_ok),
		.stride    (geo_stride),
		.sw        (geo_sw),
		.sh        (geo_sh),
		.xo        (geo_xo),
		.yo        (geo_yo)
	);

	// Stage enables ripple back from the output so bubbles are squeezed out.
	logic          en1, en2, en3, en4;
	logic [CO-1:0] en_d;
	logic          v1_s1, v2_s2, v3_s3, v4_s4;
	logic [CO-1:0] v_d;

	assign en4      = !v4_s4 || out_ready;
	assign en3      = !v3_s3 || en4;
	assign en2      = !v2_s2 || en_d[0];
	assign en1      = !v1_s1 || en2;
	assign in_ready = en1 && !geo_busy;

	// Stage 1: canvas window test and offset removal.
	logic          ok_s1, in_s1;
	logic [CB-1:0] x_s1, y_s1;
	logic          hit;

	always_comb begin
		hit = geo_ok && (canvas_x < target_q) && (canvas_y < target_q) &&
		      (canvas_x >= geo_xo) && (canvas_y >= geo_yo) &&
		      ({1'b0, canvas_x} < ({1'b0, geo_xo} + {1'b0, geo_sw})) &&
		      ({1'b0, canvas_y} < ({1'b0, geo_yo} + {1'b0, geo_sh}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (en1) begin
			v1_s1 <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			ok_s1 <= geo_ok;
			in_s1 <= hit;
			x_s1  <= canvas_x - geo_xo;
			y_s1  <= canvas_y - geo_yo;
		end
	end

	// Stage 2: scale the image offsets by the source size.
	logic          ok_s2, in_s2;
	logic [NW-1:0] nx_s2, ny_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (en2) begin
			v2_s2 <= v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			ok_s2 <= ok_s1;
			in_s2 <= in_s1;
			nx_s2 <= NW'(x_s1 * width_q);
			ny_s2 <= NW'(y_s1 * height_q);
		end
	end

	// Divider stages: one quotient bit per stage. The quotient is below the source size,
	// so the upper numerator bits start out below the divisor.
	logic [CB-1:0] rx_d [CO];
	logic [CB-1:0] ry_d [CO];
	logic [CO-1:0] lx_d [CO];
	logic [CO-1:0] ly_d [CO];
	logic [CO-1:0] qx_d [CO];
	logic [CO-1:0] qy_d [CO];
	logic [CO-1:0] ok_d, in_d;

	for (genvar k = 0; k < CO; k++) begin : g_div
		logic [CB-1:0] rx_in, ry_in;
		logic [CO-1:0] lx_in, ly_in, qx_in, qy_in;
		logic          ok_in, in_in, v_in;
		logic [CB:0]   tx, ty;
		logic          gx, gy;

		if (k == 0) begin : g_first
			assign rx_in = nx_s2[NW-1:CO];
			assign ry_in = ny_s2[NW-1:CO];
			assign lx_in = nx_s2[CO-1:0];
			assign ly_in = ny_s2[CO-1:0];
			assign qx_in = '0;
			assign qy_in = '0;
			assign ok_in = ok_s2;
			assign in_in = in_s2;
			assign v_in  = v2_s2;
		end else begin : g_next
			assign rx_in = rx_d[k-1];
			assign ry_in = ry_d[k-1];
			assign lx_in = lx_d[k-1];
			assign ly_in = ly_d[k-1];
			assign qx_in = qx_d[k-1];
			assign qy_in = qy_d[k-1];
			assign ok_in = ok_d[k-1];
			assign in_in = in_d[k-1];
			assign v_in  = v_d[k-1];
		end

		if (k == CO - 1) begin : g_en_last
			assign en_d[k] = !v_d[k] || en3;
		end else begin : g_en_mid
			assign en_d[k] = !v_d[k] || en_d[k+1];
		end

		assign tx = {rx_in, lx_in[CO-1]};
		assign ty = {ry_in, ly_in[CO-1]};
		assign gx = tx >= {1'b0, geo_sw};
		assign gy = ty >= {1'b0, geo_sh};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[k] <= 1'b0;
			end else if (en_d[k]) begin
				v_d[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en_d[k]) begin
				rx_d[k] <= gx ? CB'(tx - {1'b0, geo_sw}) : tx[CB-1:0];
				ry_d[k] <= gy ? CB'(ty - {1'b0, geo_sh}) : ty[CB-1:0];
				lx_d[k] <= lx_in << 1;
				ly_d[k] <= ly_in << 1;
				qx_d[k] <= {qx_in[CO-2:0], gx};
				qy_d[k] <= {qy_in[CO-2:0], gy};
				ok_d[k] <= ok_in;
				in_d[k] <= in_in;
			end
		end
	end

	// Stage 3: row offset, the clamped source row times the stride.
	logic          ok_s3, in_s3;
	logic [PW-1:0] prod_s3;
	logic [CO-1:0] sx_s3;
	logic [CO-1:0] qx_fin, qy_fin, sx_c, sy_c;

	assign qx_fin = qx_d[CO-1];
	assign qy_fin = qy_d[CO-1];
	assign sx_c   = (qx_fin > width_q - CO'(1)) ? width_q - CO'(1) : qx_fin;
	assign sy_c   = (qy_fin > height_q - CO'(1)) ? height_q - CO'(1) : qy_fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_s3 <= 1'b0;
		end else if (en3) begin
			v3_s3 <= v_d[CO-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			ok_s3   <= ok_d[CO-1];
			in_s3   <= in_d[CO-1];
			prod_s3 <= sy_c * geo_stride;
			sx_s3   <= sx_c;
		end
	end

	// Stage 4: output register for row offset plus column, or zero outside the image.
	logic          ok_s4, in_s4;
	logic [LB-1:0] idx_s4;
	logic [SUMW-1:0] sum;

	assign sum = SUMW'(prod_s3) + SUMW'(sx_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v4_s4 <= 1'b0;
		end else if (en4) begin
			v4_s4 <= v3_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			ok_s4  <= ok_s3;
			in_s4  <= in_s3;
			idx_s4 <= in_s3 ? sum[LB-1:0] : '0;
		end
	end

	assign out_valid = v4_s4;
	assign frame_ok  = ok_s4;
	assign in_image  = in_s4;
	assign src_index = idx_s4;

endmodule

`default_nettype wire
